### design/sntl_pkg.sv
// sntl_pkg: shared constants for the sorted name table lookup.
// Holds operation and status codes and the raw name layout.
// No dependencies.
package sntl_pkg;

   localparam int NAME_IN_BYTES = 12;
   localparam int NAME_IN_W     = 8 * NAME_IN_BYTES;

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

endpackage

### design/sntl_key_norm.sv
// sntl_key_norm: turns a raw 12-byte name into the compare key.
// Drops bytes past NAME_BYTES and zeroes every byte after the first zero byte.
// Depends on sntl_pkg.
module sntl_key_norm
   import sntl_pkg::*;
#(
   parameter int NAME_BYTES = 12,
   localparam int KEY_BYTES = (NAME_BYTES < NAME_IN_BYTES) ? NAME_BYTES : NAME_IN_BYTES,
   localparam int KEY_W     = 8 * KEY_BYTES
) (
   input  logic [NAME_IN_W-1:0] raw_name,
   output logic [KEY_W-1:0]     key
);

   always_comb begin
      logic       ended;
      logic [7:0] byte_v;
      ended = 1'b0;
      key   = '0;
      for (int i = 0; i < KEY_BYTES; i++) begin
         byte_v = raw_name[NAME_IN_W-1-8*i -: 8];
         if (ended) begin
            byte_v = 8'd0;
         end
         if (byte_v == 8'd0) begin
            ended = 1'b1;
         end
         key[KEY_W-1-8*i -: 8] = byte_v;
      end
   end

endmodule

### design/sorted_name_table_lookup.sv
// sorted_name_table_lookup: top level of the sorted name table.
// Table memory, search and shift sequencer, shared key comparator, output register.
// Depends on sntl_pkg and sntl_key_norm.
//
// Usage: the req_ channel carries an op (clear, insert, lookup) and a name of up to
// twelve bytes; the rsp_ channel returns one transfer per request with status, load
// position and the number of names held afterwards. Entries sit in one memory word
// each (name key and position), single write port, one registered read port.
// Flow, with n names held and s <= ceil(log2(n+1)) search steps:
//   clear, full insert, unused op: straight from the start state to the result.
//   lookup: s search steps, plus a check read when the search ends inside the table.
//   insert: s search steps, then k entries moved up one place (0 to n), then the new entry.
// Each search step reads the middle entry and then compares it; the shift moves one entry
// per cycle over the single memory port.
// One request is in work at a time; req_stall is high from acceptance until the result
// is loaded into the output register, which may still hold an earlier result.
// Reset empties the table at once (count to zero) and drops any pending result.
// A stalled result holds in the output register; a finished request waits for it.
module sorted_name_table_lookup
   import sntl_pkg::*;
#(
   parameter int TABLE_DEPTH = 64,
   parameter int NAME_BYTES  = 12,
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_op,
   input  logic [63:0]          req_name_high,
   input  logic [31:0]          req_name_low,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_status,
   output logic [IDX_W-1:0]     rsp_position,
   output logic [CNT_W-1:0]     rsp_entry_count
);

   localparam int KEY_BYTES = (NAME_BYTES < NAME_IN_BYTES) ? NAME_BYTES : NAME_IN_BYTES;
   localparam int KEY_W     = 8 * KEY_BYTES;
   localparam int WORD_W    = KEY_W + IDX_W;

   typedef enum logic [2:0] {
      S_IDLE, S_START, S_SEARCH, S_COMPARE, S_SHIFT, S_PLACE, S_CHECK, S_RESP
   } state_type;

   logic [WORD_W-1:0] table_mem [TABLE_DEPTH];

   state_type            state_ff,     state_in;
   logic [1:0]           op_ff,        op_in;
   logic [NAME_IN_W-1:0] name_ff,      name_in;
   logic [KEY_W-1:0]     key_ff,       key_in;
   logic [CNT_W-1:0]     held_ff,      held_in;
   logic [CNT_W-1:0]     left_ff,      left_in;
   logic [CNT_W-1:0]     right_ff,     right_in;
   logic [IDX_W-1:0]     mid_ff,       mid_in;
   logic [IDX_W-1:0]     idx_ff,       idx_in;
   logic                 pend_ff,      pend_in;
   logic [1:0]           res_status_ff, res_status_in;
   logic [IDX_W-1:0]     res_pos_ff,   res_pos_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]     rsp_pos_ff,   rsp_pos_in;
   logic [CNT_W-1:0]     rsp_count_ff, rsp_count_in;

   logic [WORD_W-1:0]    rd_data_ff;
   logic                 rd_en;
   logic [IDX_W-1:0]     rd_addr;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [WORD_W-1:0]    wr_data;

   logic [KEY_W-1:0]     key_w;
   logic [KEY_W-1:0]     entry_key;
   logic                 entry_lt;
   logic                 entry_eq;
   logic [CNT_W-1:0]     mid_full;
   logic [IDX_W-1:0]     idx_next;

   sntl_key_norm #(.NAME_BYTES(NAME_BYTES)) u_key_norm (
      .raw_name (name_ff),
      .key      (key_w)
   );

   assign entry_key = rd_data_ff[WORD_W-1:IDX_W];
   assign entry_lt  = entry_key < key_ff;
   assign entry_eq  = entry_key == key_ff;
   assign mid_full  = left_ff + ((right_ff - left_ff) >> 1);
   assign idx_next  = pend_ff ? (idx_ff - IDX_W'(1)) : idx_ff;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      name_in       = name_ff;
      key_in        = key_ff;
      held_in       = held_ff;
      left_in       = left_ff;
      right_in      = right_ff;
      mid_in        = mid_ff;
      idx_in        = idx_ff;
      pend_in       = pend_ff;
      res_status_in = res_status_ff;
      res_pos_in    = res_pos_ff;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_op;
               name_in  = {req_name_high, req_name_low};
               state_in = S_START;
            end
         end
         S_START: begin
            key_in        = key_w;
            res_status_in = STATUS_OK;
            res_pos_in    = '0;
            left_in       = '0;
            right_in      = held_ff;
            state_in      = S_RESP;
            case (op_ff)
               OP_CLEAR: begin
                  held_in = '0;
               end
               OP_INSERT: begin
                  if (held_ff == CNT_W'(TABLE_DEPTH)) begin
                     res_status_in = STATUS_FULL;
                  end else begin
                     state_in = S_SEARCH;
                  end
               end
               OP_LOOKUP: begin
                  state_in = S_SEARCH;
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end
         S_SEARCH: begin
            if (left_ff < right_ff) begin
               rd_en    = 1'b1;
               rd_addr  = mid_full[IDX_W-1:0];
               mid_in   = mid_full[IDX_W-1:0];
               state_in = S_COMPARE;
            end else if (op_ff == OP_INSERT) begin
               idx_in   = held_ff[IDX_W-1:0];
               pend_in  = 1'b0;
               state_in = S_SHIFT;
            end else if (left_ff < held_ff) begin
               rd_en    = 1'b1;
               rd_addr  = left_ff[IDX_W-1:0];
               state_in = S_CHECK;
            end else begin
               res_status_in = STATUS_NOT_FOUND;
               state_in      = S_RESP;
            end
         end
         S_COMPARE: begin
            if ((op_ff == OP_INSERT) ? (entry_lt || entry_eq) : entry_lt) begin
               left_in = CNT_W'(mid_ff) + CNT_W'(1);
            end else begin
               right_in = CNT_W'(mid_ff);
            end
            state_in = S_SEARCH;
         end
         S_SHIFT: begin
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = idx_ff;
               wr_data = rd_data_ff;
            end
            if (CNT_W'(idx_next) > left_ff) begin
               rd_en   = 1'b1;
               rd_addr = idx_next - IDX_W'(1);
               pend_in = 1'b1;
               idx_in  = idx_next;
            end else begin
               pend_in  = 1'b0;
               state_in = S_PLACE;
            end
         end
         S_PLACE: begin
            wr_en      = 1'b1;
            wr_addr    = left_ff[IDX_W-1:0];
            wr_data    = {key_ff, held_ff[IDX_W-1:0]};
            res_pos_in = held_ff[IDX_W-1:0];
            held_in    = held_ff + CNT_W'(1);
            state_in   = S_RESP;
         end
         S_CHECK: begin
            if (entry_eq) begin
               res_pos_in = rd_data_ff[IDX_W-1:0];
            end else begin
               res_status_in = STATUS_NOT_FOUND;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_pos_in    = res_pos_ff;
               rsp_count_in  = held_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         held_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         op_ff         <= op_in;
         name_ff       <= name_in;
         key_ff        <= key_in;
         held_ff       <= held_in;
         left_ff       <= left_in;
         right_ff      <= right_in;
         mid_ff        <= mid_in;
         idx_ff        <= idx_in;
         pend_ff       <= pend_in;
         res_status_ff <= res_status_in;
         res_pos_ff    <= res_pos_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_status_ff <= rsp_status_in;
         rsp_pos_ff    <= rsp_pos_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= table_mem[rd_addr];
      end
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_position    = rsp_pos_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule
